// ===== src/pcf_pkg.sv =====
// pcf_pkg: shared types, constants and helpers of the path contour flattener
// depends on nothing; used by the channel interfaces and every module

package pcf_pkg;

	localparam int COORD_W  = 24;
	localparam int SEG_LOG2 = 6;
	localparam int SEGMENTS = 1 << SEG_LOG2;
	localparam int SCALE_SH = 3 * SEG_LOG2;
	localparam int ACC_W    = COORD_W + SCALE_SH + 6;
	localparam int PRE_W    = 32;
	localparam int CNT_W    = SEG_LOG2;
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [PRE_W-1:0]   pre_t;

	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_LINE  = 2'd1,
		OP_CUBIC = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_NEW     = 2'd2
	} act_t;

	typedef enum logic {
		KIND_POINT = 1'b0,
		KIND_CUBIC = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_PREP = 2'd1,
		B_RUN  = 2'd2
	} bstate_t;

	// queued command: a single point lives in c1x/c1y
	typedef struct packed {
		kind_t  kind;
		act_t   act;
		coord_t p0x;
		coord_t p0y;
		coord_t c1x;
		coord_t c1y;
		coord_t c2x;
		coord_t c2y;
		coord_t p2x;
		coord_t p2y;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t data;
	} qwr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic coord_t sat_coord(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[COORD_W-1:0];
		else if (v < lo)
			return lo[COORD_W-1:0];
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

// ===== src/pcf_channels.sv =====
// pcf_cmd_if and pcf_pt_if: valid/ready channels for path commands and contour points
// depends on pcf_pkg

interface pcf_cmd_if;
	import pcf_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	coord_t     first_x;
	coord_t     first_y;
	coord_t     second_x;
	coord_t     second_y;
	coord_t     end_x;
	coord_t     end_y;

	modport source (output valid, operation, first_x, first_y, second_x, second_y,
		end_x, end_y, input ready);
	modport sink (input valid, operation, first_x, first_y, second_x, second_y,
		end_x, end_y, output ready);
endinterface

interface pcf_pt_if;
	import pcf_pkg::*;
	logic       valid;
	logic       ready;
	coord_t     point_x;
	coord_t     point_y;
	logic [1:0] contour_action;
	logic       last_of_run;

	modport source (output valid, point_x, point_y, contour_action, last_of_run,
		input ready);
	modport sink (input valid, point_x, point_y, contour_action, last_of_run,
		output ready);
endinterface

// ===== src/pcf_front.sv =====
// pcf_front: accepts path commands, tracks pen and contour fill, queues work
// depends on pcf_pkg and pcf_cmd_if

module pcf_front (
	input  logic            clk,
	input  logic            arst_n,
	pcf_cmd_if.sink         cmd,
	input  pcf_pkg::qstat_t qstat,
	output pcf_pkg::qwr_t   qwr
);
	import pcf_pkg::*;

	coord_t     pen_x_q;
	coord_t     pen_y_q;
	logic [1:0] fill_q;
	coord_t     pen_x_d;
	coord_t     pen_y_d;
	logic [1:0] fill_d;
	logic       accept;

	assign cmd.ready = !qstat.full;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		pen_x_d       = pen_x_q;
		pen_y_d       = pen_y_q;
		fill_d        = fill_q;
		qwr.push      = 1'b0;
		qwr.data.kind = KIND_POINT;
		qwr.data.act  = ACT_APPEND;
		qwr.data.p0x  = pen_x_q;
		qwr.data.p0y  = pen_y_q;
		qwr.data.c1x  = cmd.first_x;
		qwr.data.c1y  = cmd.first_y;
		qwr.data.c2x  = cmd.second_x;
		qwr.data.c2y  = cmd.second_y;
		qwr.data.p2x  = cmd.end_x;
		qwr.data.p2y  = cmd.end_y;
		case (cmd.operation)
			OP_MOVE: begin
				qwr.push = accept;
				case (fill_q)
					2'd0:    qwr.data.act = ACT_APPEND;
					2'd1:    qwr.data.act = ACT_REPLACE;
					default: qwr.data.act = ACT_NEW;
				endcase
				pen_x_d = cmd.first_x;
				pen_y_d = cmd.first_y;
				fill_d  = 2'd1;
			end
			OP_LINE: begin
				qwr.push = accept;
				pen_x_d  = cmd.first_x;
				pen_y_d  = cmd.first_y;
				fill_d   = (fill_q == 2'd2) ? 2'd2 : fill_q + 2'd1;
			end
			OP_CUBIC: begin
				qwr.push      = accept;
				qwr.data.kind = KIND_CUBIC;
				pen_x_d       = cmd.end_x;
				pen_y_d       = cmd.end_y;
				fill_d        = 2'd2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			fill_q  <= 2'd0;
		end else if (accept) begin
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			fill_q  <= fill_d;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("contour fill out of range");

endmodule

// ===== src/pcf_fifo.sv =====
// pcf_fifo: short command queue between front and back
// depends on pcf_pkg

module pcf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  pcf_pkg::qwr_t   qwr,
	input  logic            pop,
	output pcf_pkg::cmd_t   head,
	output pcf_pkg::qstat_t qstat
);
	import pcf_pkg::*;

	cmd_t              ent_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = ent_q[rd_ptr_q];
	assign do_push     = qwr.push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(Q_DEPTH - 1))
			return '0;
		else
			return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= qwr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qwr.push && qstat.full))
		else $error("push into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(Q_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== src/pcf_back.sv =====
// pcf_back: emits queued points and flattens cubics by forward differencing
// depends on pcf_pkg and pcf_pt_if

module pcf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pcf_pkg::cmd_t   head,
	input  pcf_pkg::qstat_t qstat,
	output logic            pop,
	pcf_pt_if.source        pt
);
	import pcf_pkg::*;

	localparam acc_t HALF = acc_t'(1) <<< (SCALE_SH - 1);

	bstate_t          state_q;
	bstate_t          state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             can_load;
	logic             load_point;
	logic             load_pre;
	logic             load_acc;
	logic             step;
	logic             last_step;

	coord_t p0_q   [2];
	pre_t   a3_q   [2];
	pre_t   b3_q   [2];
	pre_t   c_q    [2];
	pre_t   c6_q   [2];
	acc_t   f_q    [2];
	acc_t   df_q   [2];
	acc_t   ddf_q  [2];
	acc_t   dddf_q [2];

	coord_t hp0 [2];
	coord_t hc1 [2];
	coord_t hc2 [2];
	coord_t hp2 [2];
	acc_t   f_n [2];

	logic   out_valid_q;
	coord_t px_q;
	coord_t py_q;
	act_t   act_q;
	logic   last_q;

	assign hp0[0] = head.p0x;
	assign hp0[1] = head.p0y;
	assign hc1[0] = head.c1x;
	assign hc1[1] = head.c1y;
	assign hc2[0] = head.c2x;
	assign hc2[1] = head.c2y;
	assign hp2[0] = head.p2x;
	assign hp2[1] = head.p2y;

	assign can_load  = !out_valid_q || pt.ready;
	assign last_step = (cnt_q == CNT_W'(SEGMENTS - 1));

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load_point = 1'b0;
		load_pre   = 1'b0;
		load_acc   = 1'b0;
		step       = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					if (head.kind == KIND_CUBIC) begin
						pop      = 1'b1;
						load_pre = 1'b1;
						state_d  = B_PREP;
					end else if (can_load) begin
						pop        = 1'b1;
						load_point = 1'b1;
					end
				end
			end
			B_PREP: begin
				load_acc = 1'b1;
				state_d  = B_RUN;
			end
			B_RUN: begin
				if (can_load) begin
					step = 1'b1;
					if (last_step)
						state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// per-axis polynomial terms, then scaled difference terms
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (load_pre) begin
				pre_t p0;
				pre_t c1;
				pre_t c2;
				pre_t p2;
				pre_t a;
				pre_t b;
				pre_t c;
				pre_t d;
				p0 = pre_t'(hp0[i]);
				c1 = pre_t'(hc1[i]);
				c2 = pre_t'(hc2[i]);
				p2 = pre_t'(hp2[i]);
				a  = c1 - p0;
				b  = p0 - (c1 <<< 1) + c2;
				d  = c1 - c2;
				c  = d + (d <<< 1) - p0 + p2;
				p0_q[i] <= hp0[i];
				a3_q[i] <= a + (a <<< 1);
				b3_q[i] <= b + (b <<< 1);
				c_q[i]  <= c;
				c6_q[i] <= (c <<< 1) + (c <<< 2);
			end
			if (load_acc) begin
				f_q[i]    <= (acc_t'(p0_q[i]) <<< SCALE_SH) + HALF;
				df_q[i]   <= (acc_t'(a3_q[i]) <<< (2 * SEG_LOG2))
					+ (acc_t'(b3_q[i]) <<< SEG_LOG2) + acc_t'(c_q[i]);
				ddf_q[i]  <= (acc_t'(b3_q[i]) <<< (SEG_LOG2 + 1)) + acc_t'(c6_q[i]);
				dddf_q[i] <= acc_t'(c6_q[i]);
			end else if (step) begin
				f_q[i]   <= f_n[i];
				df_q[i]  <= df_q[i] + ddf_q[i];
				ddf_q[i] <= ddf_q[i] + dddf_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++)
			f_n[i] = f_q[i] + df_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (load_acc)
			cnt_q <= '0;
		else if (step)
			cnt_q <= cnt_q + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_point || step)
			out_valid_q <= 1'b1;
		else if (pt.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_point) begin
			px_q   <= head.c1x;
			py_q   <= head.c1y;
			act_q  <= head.act;
			last_q <= 1'b1;
		end else if (step) begin
			px_q   <= sat_coord(f_n[0] >>> SCALE_SH);
			py_q   <= sat_coord(f_n[1] >>> SCALE_SH);
			act_q  <= ACT_APPEND;
			last_q <= last_step;
		end
	end

	assign pt.valid          = out_valid_q;
	assign pt.point_x        = px_q;
	assign pt.point_y        = py_q;
	assign pt.contour_action = act_q;
	assign pt.last_of_run    = last_q;

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN && step && last_step) |=> state_q == B_IDLE)
		else $error("cubic run did not end after its last point");

	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> state_q == B_RUN)
		else $error("non-final point outside a cubic run");

	a_prep_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		load_pre |=> state_q == B_PREP && $past(!qstat.empty))
		else $error("cubic setup without a queued command");

endmodule

// ===== src/path_contour_flattener.sv =====
// path_contour_flattener: top level of the path contour flattener
// depends on pcf_pkg, pcf_channels, pcf_front, pcf_fifo and pcf_back
//
// cmd takes path commands (move, line, cubic) as valid/ready transactions;
// pt gives contour points, each with its contour action and a last_of_run
// flag on the final point of its command. an unknown operation is taken
// and dropped without a point.
// the front takes one command per cycle while its two-entry queue has room;
// pen and contour fill are tracked there, so acceptance waits for the back
// only through a full queue. a move or line is written into the queue, then
// loaded into the back's output register. a cubic first registers the
// polynomial terms, then the scaled difference terms, then gives SEGMENTS
// points one per cycle while pt takes them, and the back takes no new command
// until its last point. the difference accumulators set the cubic rate: one
// add per term per point. a stalled pt holds its point; the back halts and the
// queue fills, after which cmd.ready drops. reset clears the pen to 0, the
// contour to empty and both queue and output; no clearing pass is needed.

module path_contour_flattener (
	input  logic       clk,
	input  logic       arst_n,
	pcf_cmd_if.sink    cmd,
	pcf_pt_if.source   pt
);
	import pcf_pkg::*;

	qwr_t   qwr;
	qstat_t qstat;
	cmd_t   head;
	logic   pop;

	pcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.qstat  (qstat),
		.qwr    (qwr)
	);

	pcf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	pcf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.pt     (pt)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench of path_contour_flattener, predicting every contour point
// depends on pcf_pkg, pcf_channels and the path_contour_flattener rtl

module tb;
	import pcf_pkg::*;

	localparam longint      SCALE        = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
	localparam longint      COORD_MAX    = 64'sd8388607;
	localparam longint      COORD_MIN    = -64'sd8388608;
	localparam coord_t      XY_MAX       = 24'h7FFFFF;
	localparam coord_t      XY_MIN       = 24'h800000;
	localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
	localparam int          IDLE_PERCENT = 19;
	localparam int          RANDOM_ITEMS = 265;
	localparam int          DRAIN_CYCLES = SEGMENTS + 40;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          MAX_REPORTS  = 10;

	typedef struct {
		coord_t     point_x;
		coord_t     point_y;
		act_t       action;
		logic       last;
	} contour_point_t;

	logic clk = 1'b0;
	logic arst_n;

	pcf_cmd_if cmd ();
	pcf_pt_if  pt ();

	path_contour_flattener dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pt     (pt)
	);

	contour_point_t expected_points[$];
	coord_t         pen_x;
	coord_t         pen_y;
	logic [1:0]     contour_fill;
	int             mismatch_count = 0;
	int             cycle_count = 0;
	bit             no_idle;

	always #5 clk = ~clk;

	// floor((f + S/2) / S), saturated to the coordinate range
	function automatic coord_t nearest_point(input longint f);
		longint t;
		longint q;
		t = f + SCALE / 2;
		q = t / SCALE;
		if (t < 0 && (t % SCALE) != 0)
			q = q - 1;
		if (q > COORD_MAX)
			q = COORD_MAX;
		else if (q < COORD_MIN)
			q = COORD_MIN;
		return coord_t'(q[COORD_W-1:0]);
	endfunction

	function automatic void difference_terms(input longint p0, input longint c1,
			input longint c2, input longint p2, output longint f, output longint df,
			output longint ddf, output longint dddf);
		longint n;
		longint a;
		longint b;
		longint c;
		n = SEGMENTS;
		a = c1 - p0;
		b = p0 - 2 * c1 + c2;
		c = 3 * (c1 - c2) - p0 + p2;
		f = p0 * n * n * n;
		df = 3 * a * n * n + 3 * b * n + c;
		ddf = 6 * b * n + 6 * c;
		dddf = 6 * c;
	endfunction

	function automatic void predict_points(input logic [1:0] op, input coord_t x1,
			input coord_t y1, input coord_t x2, input coord_t y2, input coord_t xe,
			input coord_t ye);
		contour_point_t p;
		longint fx, dfx, ddfx, dddfx;
		longint fy, dfy, ddfy, dddfy;
		case (op)
			OP_MOVE: begin
				pen_x = x1;
				pen_y = y1;
				p.point_x = x1;
				p.point_y = y1;
				p.action = (contour_fill == 2'd0) ? ACT_APPEND :
					(contour_fill == 2'd1) ? ACT_REPLACE : ACT_NEW;
				p.last = 1'b1;
				contour_fill = 2'd1;
				expected_points = {expected_points, p};
			end
			OP_LINE: begin
				pen_x = x1;
				pen_y = y1;
				if (contour_fill < 2'd2)
					contour_fill = contour_fill + 2'd1;
				p.point_x = x1;
				p.point_y = y1;
				p.action = ACT_APPEND;
				p.last = 1'b1;
				expected_points = {expected_points, p};
			end
			OP_CUBIC: begin
				difference_terms(pen_x, x1, x2, xe, fx, dfx, ddfx, dddfx);
				difference_terms(pen_y, y1, y2, ye, fy, dfy, ddfy, dddfy);
				for (int k = 0; k < SEGMENTS; k++) begin
					fx = fx + dfx;
					dfx = dfx + ddfx;
					ddfx = ddfx + dddfx;
					fy = fy + dfy;
					dfy = dfy + ddfy;
					ddfy = ddfy + dddfy;
					p.point_x = nearest_point(fx);
					p.point_y = nearest_point(fy);
					p.action = ACT_APPEND;
					p.last = (k == SEGMENTS - 1);
					expected_points = {expected_points, p};
				end
				pen_x = xe;
				pen_y = ye;
				contour_fill = 2'd2;
			end
			default: ;
		endcase
	endfunction

	function automatic coord_t random_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return coord_t'($urandom);
		else if (r < 85)
			return coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
		else if (r < 90)
			return XY_MAX;
		else if (r < 95)
			return XY_MIN;
		else
			return coord_t'(r[0] ? -1 : 0);
	endfunction

	task automatic send_command(input logic [1:0] op, input coord_t x1, input coord_t y1,
			input coord_t x2, input coord_t y2, input coord_t xe, input coord_t ye);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.first_x <= x1;
		cmd.first_y <= y1;
		cmd.second_x <= x2;
		cmd.second_y <= y2;
		cmd.end_x <= xe;
		cmd.end_y <= ye;
		do
			@(posedge clk);
		while (!cmd.ready);
		predict_points(op, x1, y1, x2, y2, xe, ye);
	endtask

	task automatic send_random(input logic [1:0] op);
		send_command(op, random_coord(), random_coord(), random_coord(), random_coord(),
			random_coord(), random_coord());
	endtask

	// receiver side: random back-pressure
	always @(posedge clk)
		pt.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

	always @(posedge clk) begin
		contour_point_t e;
		if (arst_n && pt.valid && pt.ready) begin
			if (expected_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected point x=%0d y=%0d act=%0d last=%0b", pt.point_x,
						pt.point_y, pt.contour_action, pt.last_of_run);
			end else begin
				e = expected_points.pop_front();
				if (pt.point_x !== e.point_x || pt.point_y !== e.point_y ||
						pt.contour_action !== e.action || pt.last_of_run !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"point mismatch: expected x=%0d y=%0d act=%0d last=%0b,",
							" got x=%0d y=%0d act=%0d last=%0b"},
							e.point_x, e.point_y, e.action, e.last, pt.point_x, pt.point_y,
							pt.contour_action, pt.last_of_run);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_move_actions();
		send_command(OP_MOVE, XY_MAX, XY_MAX, XY_MIN, XY_MIN, XY_MAX, XY_MIN);
		send_command(OP_MOVE, XY_MIN, XY_MIN, XY_MAX, XY_MAX, XY_MIN, XY_MAX);
		send_command(OP_LINE, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_MOVE, -24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	task automatic test_line_fill();
		send_command(OP_MOVE, 24'sd256, -24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_LINE, XY_MAX, XY_MIN, XY_MAX, XY_MAX, XY_MAX, XY_MAX);
		send_command(OP_LINE, XY_MIN, XY_MAX, XY_MIN, XY_MIN, XY_MIN, XY_MIN);
		send_command(OP_LINE, 24'sd1, -24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	task automatic test_cubic_extremes();
		send_command(OP_MOVE, XY_MIN, XY_MIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_CUBIC, XY_MAX, XY_MAX, XY_MIN, XY_MIN, XY_MAX, XY_MAX);
		send_command(OP_CUBIC, XY_MIN, XY_MAX, XY_MAX, XY_MIN, XY_MIN, XY_MIN);
		send_command(OP_CUBIC, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_CUBIC, 24'sd300, -24'sd77, -24'sd5, 24'sd1000, 24'sd3, 24'sd3);
		send_command(OP_MOVE, 24'sd10, 24'sd20, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_CUBIC, 24'sd10, 24'sd20, 24'sd10, 24'sd20, 24'sd10, 24'sd20);
	endtask

	task automatic test_unknown_operation();
		send_command(OP_UNKNOWN, XY_MAX, XY_MAX, XY_MAX, XY_MAX, XY_MAX, XY_MAX);
		send_command(OP_LINE, 24'sd5, 24'sd6, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_command(OP_UNKNOWN, XY_MIN, XY_MIN, XY_MIN, XY_MIN, XY_MIN, XY_MIN);
		send_command(OP_MOVE, 24'sd7, 24'sd8, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	task automatic test_random_paths();
		int sent;
		int segs;
		int r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = (sent >= 110 && sent < 170);
			r = $urandom_range(0, 99);
			if (r < 88) begin
				send_random(OP_MOVE);
				sent++;
			end
			segs = $urandom_range(1, 6);
			for (int s = 0; s < segs; s++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					send_random(OP_LINE);
				else if (r < 90)
					send_random(OP_CUBIC);
				else if (r < 95)
					send_random(OP_MOVE);
				else
					send_random(OP_UNKNOWN);
				if (r < 95)
					sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.operation <= OP_MOVE;
		cmd.first_x <= '0;
		cmd.first_y <= '0;
		cmd.second_x <= '0;
		cmd.second_y <= '0;
		cmd.end_x <= '0;
		cmd.end_y <= '0;
		pen_x = '0;
		pen_y = '0;
		contour_fill = 2'd0;
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_move_actions();
		test_line_fill();
		test_cubic_extremes();
		test_unknown_operation();
		test_random_paths();

		// cmd.valid gets a single update in the step of the last transaction
		cmd.valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_points.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
